// ===== rtl/uri_percent_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// URI percent decoder assertion macros
// Shared concurrent assertion forms used across the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef URI_PERCENT_DECODER_MACROS_SVH
`define URI_PERCENT_DECODER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define UPD_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define UPD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define UPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/upd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent decoder package
// Shared types, constants and character helpers for the decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;

   localparam logic [7:0] LEAD4_MASK  = 8'hf8;
   localparam logic [7:0] LEAD4_VALUE = 8'hf0;
   localparam logic [7:0] LEAD3_MASK  = 8'hf0;
   localparam logic [7:0] LEAD3_VALUE = 8'he0;
   localparam logic [7:0] LEAD2_MASK  = 8'he0;
   localparam logic [7:0] LEAD2_VALUE = 8'hc0;
   localparam logic [1:0] CONT_TAG    = 2'b10;

   typedef enum logic [2:0] {
      PH_NORMAL = 3'd0,
      PH_HEX1   = 3'd1,
      PH_HEX2   = 3'd2,
      PH_CPCT   = 3'd3,
      PH_CHEX1  = 3'd4,
      PH_CHEX2  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      EMIT_NONE  = 3'd0,
      EMIT_INPUT = 3'd1,
      EMIT_VALUE = 3'd2,
      EMIT_KEPT  = 3'd3,
      EMIT_SEQ   = 3'd4,
      EMIT_ERR   = 3'd5,
      EMIT_DONE  = 3'd6
   } emit_type;

   // One queue entry: all results caused by one input transaction.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            err;
      logic            done;
   } burst_type;

   // Returns {valid, value} for an ASCII hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      case (c) inside
         [8'h30:8'h39]:              r = {1'b1, c[3:0]};
         [8'h41:8'h46], [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
         default:                    r = 5'd0;
      endcase
      return r;
   endfunction

   // Reserved characters kept as escapes in full-URI mode.
   function automatic logic is_kept(input logic [7:0] v);
      logic r;
      case (v) inside
         8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26,
         8'h3D, 8'h2B, 8'h24, 8'h2C, 8'h23: r = 1'b1;
         default:                           r = 1'b0;
      endcase
      return r;
   endfunction

   // Number of continuation bytes a UTF-8 lead byte calls for; zero when invalid.
   function automatic logic [1:0] lead_conts(input logic [7:0] v);
      logic [1:0] r;
      if ((v & LEAD4_MASK) == LEAD4_VALUE) begin
         r = 2'd3;
      end else if ((v & LEAD3_MASK) == LEAD3_VALUE) begin
         r = 2'd2;
      end else if ((v & LEAD2_MASK) == LEAD2_VALUE) begin
         r = 2'd1;
      end else begin
         r = 2'd0;
      end
      return r;
   endfunction

endpackage

// ===== rtl/uri_percent_decoder.sv =====
`timescale 1ns / 1ps
// A result passes through the burst queue and then the back end's output register
// before it is visible. One input transaction is accepted per cycle while the queue has room;
// a burst of up to four result bytes holds the output until each byte has been popped.
// The burst queue depth sets how long the input side runs ahead of a stalled output.
// Reset is synchronous, active high, and returns to the start of a string in component mode.
// ----------------------------------------------------------------------------
// URI percent decoder
// Decodes percent escapes of a byte stream, with optional full-URI reserved handling.
// ----------------------------------------------------------------------------
module uri_percent_decoder
   import upd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_decode_error,
   output logic       rsp_string_done,
   input  logic       csr_we,
   input  logic [0:0] csr_wdata
);

   // The front end turns every accepted transaction into at most one burst entry.
   // Inputs that only advance escape state push nothing, so the queue holds only
   // transactions that still owe results to the consumer.
   logic      accept;
   logic      burst_push;
   burst_type burst;
   logic      q_full;
   logic      q_empty;
   logic      q_pop;
   burst_type q_data;

   // An input is taken whenever the queue has a free slot; this is conservative
   // for inputs that push nothing but keeps the accept path short.
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   upd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .end_of_string (req_end_of_string),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .burst_push    (burst_push),
      .burst         (burst)
   );

   // The queue decouples decoding from the byte-by-byte unrolling of bursts.
   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (burst_push),
      .push_data (burst),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   // The back end holds the current burst in its output register and steps
   // through its bytes, refilling in the same cycle the last byte is taken if a burst is waiting.
   upd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_decode_error (rsp_decode_error),
      .rsp_string_done  (rsp_string_done)
   );

endmodule

// ===== rtl/upd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent decoder burst queue
// Small first-in first-out store of result bursts between front and back.
// ----------------------------------------------------------------------------
`include "uri_percent_decoder_macros.svh"

module upd_queue
   import upd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  burst_type push_data,
   output logic      full,
   input  logic      pop,
   output burst_type pop_data,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   burst_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `UPD_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")
   `UPD_ASSERT_IMPLY(a_no_push_full, clock, reset, push, !full, "push into a full queue")
   `UPD_ASSERT_IMPLY(a_no_pop_empty, clock, reset, pop, !empty, "pop from an empty queue")
   `UPD_ASSERT_NEXT(a_count_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not grow on push")

endmodule

// ===== rtl/upd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent decoder front end
// Accepts encoded bytes, tracks escape state and builds result bursts.
// ----------------------------------------------------------------------------
module upd_front
   import upd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  logic [7:0] in_byte,
   input  logic      end_of_string,
   input  logic      csr_we,
   input  logic [0:0] csr_wdata,
   output logic      burst_push,
   output burst_type burst
);

   phase_type        phase_ff, phase_in;
   logic [3:0]       high_nibble_ff, high_nibble_in;
   logic [7:0]       high_char_ff, high_char_in;
   logic [1:0]       cont_ff, cont_in;
   logic [3:0][7:0]  seq_ff, seq_in;
   logic [2:0]       seq_cnt_ff, seq_cnt_in;
   logic             err_latched_ff, err_latched_in;
   logic             mode_ff;

   logic [4:0]       hex;
   logic             hex_ok;
   logic [7:0]       value;
   logic [1:0]       lead;
   phase_type        ph_step;
   logic             bad;
   emit_type         kind;

   assign hex    = hex_digit(in_byte);
   assign hex_ok = hex[4];
   assign value  = {high_nibble_ff, hex[3:0]};
   assign lead   = lead_conts(value);

   // Next-state logic: escape tracking, error detection and string clearing.
   always_comb begin
      ph_step        = phase_ff;
      bad            = 1'b0;
      kind           = EMIT_NONE;
      phase_in       = phase_ff;
      high_nibble_in = high_nibble_ff;
      high_char_in   = high_char_ff;
      cont_in        = cont_ff;
      seq_in         = seq_ff;
      seq_cnt_in     = seq_cnt_ff;
      err_latched_in = err_latched_ff;

      unique case (phase_ff)
         PH_HEX1, PH_CHEX1: begin
            if (!hex_ok) begin
               bad = 1'b1;
            end else begin
               ph_step        = (phase_ff == PH_HEX1) ? PH_HEX2 : PH_CHEX2;
               high_nibble_in = hex[3:0];
               high_char_in   = in_byte;
            end
         end
         PH_HEX2: begin
            if (!hex_ok) begin
               bad = 1'b1;
            end else if (value[7]) begin
               if (lead == 2'd0) begin
                  bad = 1'b1;
               end else begin
                  ph_step    = PH_CPCT;
                  seq_in[0]  = value;
                  seq_cnt_in = 3'd1;
                  cont_in    = lead;
               end
            end else begin
               ph_step = PH_NORMAL;
               kind    = (mode_ff && is_kept(value)) ? EMIT_KEPT : EMIT_VALUE;
            end
         end
         PH_CPCT: begin
            if (in_byte != CHAR_PERCENT) begin
               bad = 1'b1;
            end else begin
               ph_step = PH_CHEX1;
            end
         end
         PH_CHEX2: begin
            if (!hex_ok || value[7:6] != CONT_TAG) begin
               bad = 1'b1;
            end else begin
               seq_in[seq_cnt_ff[1:0]] = value;
               seq_cnt_in             = seq_cnt_ff + 3'd1;
               cont_in                = cont_ff - 2'd1;
               if (cont_ff == 2'd1) begin
                  ph_step    = PH_NORMAL;
                  kind       = EMIT_SEQ;
                  seq_cnt_in = 3'd0;
               end else begin
                  ph_step = PH_CPCT;
               end
            end
         end
         default: begin
            if (in_byte == CHAR_PERCENT) begin
               ph_step = PH_HEX1;
            end else begin
               ph_step = PH_NORMAL;
               kind    = EMIT_INPUT;
            end
         end
      endcase

      // An escape left open at the end of the string is malformed.
      if (end_of_string && ph_step != PH_NORMAL) begin
         bad = 1'b1;
      end

      if (err_latched_ff) begin
         kind = end_of_string ? EMIT_ERR : EMIT_NONE;
      end else if (bad) begin
         kind = EMIT_ERR;
      end else if (kind == EMIT_NONE && end_of_string) begin
         kind = EMIT_DONE;
      end

      phase_in = ph_step;
      if (err_latched_ff) begin
         phase_in       = phase_ff;
         high_nibble_in = high_nibble_ff;
         high_char_in   = high_char_ff;
         cont_in        = cont_ff;
         seq_in         = seq_ff;
         seq_cnt_in     = seq_cnt_ff;
      end else if (bad) begin
         err_latched_in = 1'b1;
      end

      if (end_of_string) begin
         phase_in       = PH_NORMAL;
         high_nibble_in = '0;
         high_char_in   = '0;
         cont_in        = '0;
         seq_cnt_in     = '0;
         err_latched_in = 1'b0;
      end
   end

   // Output logic: the burst of results for this transaction.
   always_comb begin
      burst          = '0;
      burst.done     = end_of_string;
      burst_push     = accept && (kind != EMIT_NONE);
      unique case (kind)
         EMIT_INPUT: burst.bytes[0] = in_byte;
         EMIT_VALUE: burst.bytes[0] = value;
         EMIT_KEPT: begin
            burst.bytes[0] = CHAR_PERCENT;
            burst.bytes[1] = high_char_ff;
            burst.bytes[2] = in_byte;
            burst.last_idx = 2'd2;
         end
         EMIT_SEQ: begin
            for (int i = 0; i < 4; i++) begin
               burst.bytes[i] = (seq_cnt_ff[1:0] == 2'(i)) ? value : seq_ff[i];
            end
            burst.last_idx = seq_cnt_ff[1:0];
         end
         EMIT_ERR:  burst.err = 1'b1;
         default:   burst.err = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_NORMAL;
         high_nibble_ff <= '0;
         high_char_ff   <= '0;
         cont_ff        <= '0;
         seq_cnt_ff     <= '0;
         err_latched_ff <= 1'b0;
         mode_ff        <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            high_nibble_ff <= high_nibble_in;
            high_char_ff   <= high_char_in;
            cont_ff        <= cont_in;
            seq_cnt_ff     <= seq_cnt_in;
            err_latched_ff <= err_latched_in;
         end
         if (csr_we) begin
            mode_ff <= csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seq_ff <= seq_in;
      end
   end

endmodule

// ===== rtl/upd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent decoder back end
// Unrolls queued bursts into single result bytes on the output register.
// ----------------------------------------------------------------------------
module upd_back
   import upd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  burst_type q_data,
   output logic      q_pop,
   output logic      rsp_empty,
   input  logic      rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic      rsp_last_of_run,
   output logic      rsp_decode_error,
   output logic      rsp_string_done
);

   burst_type  cur_ff;
   logic [1:0] idx_ff;
   logic       valid_ff;
   logic       at_last;
   logic       take;
   logic       load;

   assign at_last = (idx_ff == cur_ff.last_idx);
   assign take    = valid_ff && rsp_pop;
   assign load    = (!valid_ff || (take && at_last)) && !q_empty;
   assign q_pop   = load;

   assign rsp_empty        = !valid_ff;
   assign rsp_out_byte     = cur_ff.bytes[idx_ff];
   assign rsp_last_of_run  = at_last;
   assign rsp_decode_error = cur_ff.err;
   assign rsp_string_done  = cur_ff.done && at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (take) begin
         if (at_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_data;
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent decoder testbench
// Drives encoded strings into the decoder one byte per transaction and
// predicts every decoded byte, error and string-end flag. Each result
// transaction is checked in order against the prediction. Covers component
// and full-URI modes, valid escapes and multi-byte sequences, malformed input
// and truncated strings, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_top
   import upd_pkg::*;
();

   // The longest quiet stretch in a correct run is the forced output stall,
   // so the limit leaves a wide margin.
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 100;

   // Reserved characters that full-URI mode keeps as escapes. The generator
   // picks from these often so that mode changes actually matter.
   localparam logic [7:0] RESERVED_SET [0:10] = '{
      8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B, 8'h24, 8'h2C, 8'h23
   };

   // One result transaction as seen on the rsp_ ports.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
      logic       done;
   } decoded_type;

   // One input transaction as offered on the req_ ports.
   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } encoded_type;

   // -------------------------------------------------------------------------
   // Decoder model and result checker. The model keeps its own copy of the
   // escape parser state and the mode register and turns every accepted input
   // byte into the burst of results the block must produce for it.
   // -------------------------------------------------------------------------
   class decode_scoreboard;
      decoded_type expected_bytes[$];
      bit          reserved_mode;
      int          mismatches;
      phase_type   parse_phase;
      logic [3:0]  high_nibble;
      logic [7:0]  high_char;
      logic [1:0]  conts_left;
      logic [7:0]  seq_bytes[4];
      int          seq_count;
      bit          swallowing;

      function new();
         mismatches    = 0;
         reserved_mode = 1'b0;
         clear_string();
      endfunction

      function void clear_string();
         parse_phase = PH_NORMAL;
         high_nibble = 4'd0;
         high_char   = 8'd0;
         conts_left  = 2'd0;
         seq_count   = 0;
         swallowing  = 1'b0;
         for (int i = 0; i < 4; i++) begin
            seq_bytes[i] = 8'd0;
         end
      endfunction

      function int hex_val(logic [7:0] c);
         if (c >= "0" && c <= "9") begin
            return int'(c) - int'("0");
         end
         if (c >= "a" && c <= "f") begin
            return int'(c) - int'("a") + 10;
         end
         if (c >= "A" && c <= "F") begin
            return int'(c) - int'("A") + 10;
         end
         return -1;
      endfunction

      function bit is_reserved(logic [7:0] v);
         case (v)
            8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26,
            8'h3D, 8'h2B, 8'h24, 8'h2C, 8'h23: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function logic [1:0] lead_count(logic [7:0] v);
         if ((v & LEAD4_MASK) == LEAD4_VALUE) begin
            return 2'd3;
         end
         if ((v & LEAD3_MASK) == LEAD3_VALUE) begin
            return 2'd2;
         end
         if ((v & LEAD2_MASK) == LEAD2_VALUE) begin
            return 2'd1;
         end
         return 2'd0;
      endfunction

      function decoded_type plain(logic [7:0] b);
         decoded_type r;
         r.data = b;
         r.last = 1'b0;
         r.err  = 1'b0;
         r.done = 1'b0;
         return r;
      endfunction

      // Predicts the results of one accepted input byte.
      function void decode_input(logic [7:0] b, logic eos);
         decoded_type burst[$];
         decoded_type fail_item;
         bit          bad;
         int          h;
         logic [7:0]  v;
         logic [1:0]  conts;
         bad = 1'b0;
         fail_item.data = 8'd0;
         fail_item.last = 1'b1;
         fail_item.err  = 1'b1;
         fail_item.done = eos;
         if (swallowing) begin
            if (eos) begin
               expected_bytes.push_back(fail_item);
               clear_string();
            end
            return;
         end
         case (parse_phase)
            PH_HEX1, PH_CHEX1: begin
               h = hex_val(b);
               if (h < 0) begin
                  bad = 1'b1;
               end else begin
                  high_nibble = h[3:0];
                  high_char   = b;
                  parse_phase = (parse_phase == PH_HEX1) ? PH_HEX2 : PH_CHEX2;
               end
            end
            PH_HEX2: begin
               h = hex_val(b);
               if (h < 0) begin
                  bad = 1'b1;
               end else begin
                  v = {high_nibble, h[3:0]};
                  if (v[7]) begin
                     conts = lead_count(v);
                     if (conts == 2'd0) begin
                        bad = 1'b1;
                     end else begin
                        seq_bytes[0] = v;
                        seq_count    = 1;
                        conts_left   = conts;
                        parse_phase  = PH_CPCT;
                     end
                  end else if (reserved_mode && v != 8'd0 && is_reserved(v)) begin
                     burst.push_back(plain(CHAR_PERCENT));
                     burst.push_back(plain(high_char));
                     burst.push_back(plain(b));
                     parse_phase = PH_NORMAL;
                  end else begin
                     burst.push_back(plain(v));
                     parse_phase = PH_NORMAL;
                  end
               end
            end
            PH_CPCT: begin
               if (b != CHAR_PERCENT) begin
                  bad = 1'b1;
               end else begin
                  parse_phase = PH_CHEX1;
               end
            end
            PH_CHEX2: begin
               h = hex_val(b);
               if (h < 0) begin
                  bad = 1'b1;
               end else begin
                  v = {high_nibble, h[3:0]};
                  if (v[7:6] != CONT_TAG) begin
                     bad = 1'b1;
                  end else begin
                     seq_bytes[seq_count % 4] = v;
                     seq_count  = (seq_count + 1) % 8;
                     conts_left = conts_left - 2'd1;
                     if (conts_left == 2'd0) begin
                        for (int i = 0; i < seq_count && i < 4; i++) begin
                           burst.push_back(plain(seq_bytes[i]));
                        end
                        seq_count   = 0;
                        parse_phase = PH_NORMAL;
                     end else begin
                        parse_phase = PH_CPCT;
                     end
                  end
               end
            end
            default: begin
               if (b == CHAR_PERCENT) begin
                  parse_phase = PH_HEX1;
               end else begin
                  parse_phase = PH_NORMAL;
                  burst.push_back(plain(b));
               end
            end
         endcase
         // A string may not end in the middle of an escape or a sequence.
         if (!bad && eos && parse_phase != PH_NORMAL) begin
            bad = 1'b1;
         end
         if (bad) begin
            expected_bytes.push_back(fail_item);
            if (eos) begin
               clear_string();
            end else begin
               swallowing = 1'b1;
            end
            return;
         end
         if (burst.size() == 0) begin
            if (eos) begin
               fail_item.err = 1'b0;
               expected_bytes.push_back(fail_item);
               clear_string();
            end
            return;
         end
         burst[burst.size() - 1].last = 1'b1;
         burst[burst.size() - 1].done = eos;
         foreach (burst[i]) begin
            expected_bytes.push_back(burst[i]);
         end
         if (eos) begin
            clear_string();
         end
      endfunction

      // Compares one accepted result with the oldest prediction.
      function void check_decoded(decoded_type got);
         decoded_type want;
         if (expected_bytes.size() == 0) begin
            $error("unexpected result: out_byte %02h last %0b error %0b done %0b",
                   got.data, got.last, got.err, got.done);
            mismatches++;
            return;
         end
         want = expected_bytes.pop_front();
         if (got.data !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, got.data);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last_of_run: expected %0b, actual %0b", want.last, got.last);
            mismatches++;
         end
         if (got.err !== want.err) begin
            $error("decode_error: expected %0b, actual %0b", want.err, got.err);
            mismatches++;
         end
         if (got.done !== want.done) begin
            $error("string_done: expected %0b, actual %0b", want.done, got.done);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_in_byte;
   logic       req_end_of_string;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic       rsp_decode_error;
   logic       rsp_string_done;
   logic       csr_we;
   logic [0:0] csr_wdata;

   decode_scoreboard sb;
   encoded_type      string_bytes_q[$];
   bit               hold_request;
   bit               no_idle;
   int               stalled;

   uri_percent_decoder DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_decode_error  (rsp_decode_error),
      .rsp_string_done   (rsp_string_done),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
   end

   always #2 clock = ~clock;

   // All handshakes are observed here at the rising edge, before the block's
   // own registers update. A register write reaches the model at the same edge
   // as it reaches the block, and each accepted input or result transaction is
   // handed to the scoreboard in the order it crossed the interface.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            sb.reserved_mode = csr_wdata[0];
         end
         if (req_push && !req_full) begin
            sb.decode_input(req_in_byte, req_end_of_string);
         end
         if (rsp_pop && !rsp_empty) begin
            sb.check_decoded({rsp_out_byte, rsp_last_of_run, rsp_decode_error,
                              rsp_string_done});
         end
      end
   end

   // The watchdog ends the run when no transaction of either kind has been
   // accepted for far longer than any correct run would ever stay quiet.
   initial begin
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            stalled = 0;
         end else begin
            stalled++;
         end
      end
      $display("end of test: mismatches");
      $finish;
   end

   // The receiver pops at random, idle about 35 times in a hundred, except
   // during a no-idle stretch. When a hold-off is requested it keeps pop low
   // until the hold-off ends, so the block's queue fills and the sender
   // sees full while it keeps offering bytes.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !reset) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_pop <= !reset && (no_idle || $urandom_range(99) >= 35);
      end
   end

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) begin
         return "0" + n;
      end
      // Letter digits come in either case.
      return ($urandom_range(1) ? "a" : "A") + (n - 4'd10);
   endfunction

   task automatic add_byte(logic [7:0] b, logic eos);
      encoded_type item;
      item.data = b;
      item.eos  = eos;
      string_bytes_q.push_back(item);
   endtask

   task automatic add_escape(logic [7:0] v);
      add_byte(CHAR_PERCENT, 1'b0);
      add_byte(hex_char(v[7:4]), 1'b0);
      add_byte(hex_char(v[3:0]), 1'b0);
   endtask

   task automatic add_text(string s, bit eos_at_end);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i], eos_at_end && (i == s.len() - 1));
      end
   endtask

   // Builds one random string. Most pieces are well formed (plain bytes,
   // escapes and complete UTF-8 sequences) so that the parser gets deep into
   // its states; the rest are malformed escapes, bad lead or continuation
   // bytes and now and then a string cut short inside an escape.
   task automatic gen_string();
      int         start_idx;
      int         kind;
      int         n;
      logic [7:0] v;
      logic [7:0] c;
      start_idx = string_bytes_q.size();
      repeat ($urandom_range(1, 8)) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            c = 8'($urandom_range(255));
            if (c == CHAR_PERCENT) begin
               c = "." ;
            end
            add_byte(c, 1'b0);
         end else if (kind < 55) begin
            if ($urandom_range(1)) begin
               v = RESERVED_SET[$urandom_range(10)];
            end else begin
               v = 8'($urandom_range(127));
            end
            add_escape(v);
         end else if (kind < 80) begin
            n = $urandom_range(1, 3);
            case (n)
               1: v = LEAD2_VALUE | 8'($urandom_range(31));
               2: v = LEAD3_VALUE | 8'($urandom_range(15));
               default: v = LEAD4_VALUE | 8'($urandom_range(7));
            endcase
            add_escape(v);
            repeat (n) add_escape({CONT_TAG, 6'($urandom_range(63))});
         end else if (kind < 86) begin
            // A non-hex character where a hex digit is due.
            add_byte(CHAR_PERCENT, 1'b0);
            if ($urandom_range(1)) begin
               add_byte(hex_char(4'($urandom_range(15))), 1'b0);
            end
            do begin
               c = 8'($urandom_range(255));
            end while (sb.hex_val(c) >= 0);
            add_byte(c, 1'b0);
         end else if (kind < 90) begin
            // A high escape that is no valid lead byte.
            if ($urandom_range(1)) begin
               v = {CONT_TAG, 6'($urandom_range(63))};
            end else begin
               v = LEAD4_MASK | 8'($urandom_range(7));
            end
            add_escape(v);
         end else if (kind < 95) begin
            // A two-byte lead followed by something other than a continuation.
            add_escape(LEAD2_VALUE | 8'($urandom_range(31)));
            if ($urandom_range(1)) begin
               v = 8'($urandom_range(255));
               if (v[7:6] == CONT_TAG) begin
                  v[6] = 1'b1;
               end
               add_escape(v);
            end else begin
               c = 8'($urandom_range(255));
               if (c == CHAR_PERCENT) begin
                  c = "A";
               end
               add_byte(c, 1'b0);
            end
         end else begin
            add_byte(CHAR_PERCENT, 1'b0);
            add_byte(8'($urandom_range(255)), 1'b0);
         end
      end
      if (string_bytes_q.size() - start_idx > 2 && $urandom_range(99) < 8) begin
         void'(string_bytes_q.pop_back());
         if ($urandom_range(1)) begin
            void'(string_bytes_q.pop_back());
         end
      end
      string_bytes_q[string_bytes_q.size() - 1].eos = 1'b1;
   endtask

   task automatic gen_random(int count);
      int target;
      target = string_bytes_q.size() + count;
      while (string_bytes_q.size() < target) begin
         gen_string();
      end
   endtask

   // Offers queued bytes at the falling edge, idling at random, and retires a
   // byte only once the rising edge shows that its transaction was accepted.
   task automatic send_all();
      while (string_bytes_q.size() > 0) begin
         @(negedge clock);
         if (!no_idle && $urandom_range(99) < 35) begin
            req_push <= 1'b0;
         end else begin
            req_push          <= 1'b1;
            req_in_byte       <= string_bytes_q[0].data;
            req_end_of_string <= string_bytes_q[0].eos;
         end
         @(posedge clock);
         if (req_push && !req_full) begin
            void'(string_bytes_q.pop_front());
         end
      end
      @(negedge clock);
      req_push <= 1'b0;
   endtask

   // Waits for every predicted result, then lets the block settle so that bytes
   // which cause no result have also left the pipeline.
   task automatic wait_drained();
      while (sb.expected_bytes.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(bit mode);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      sb                = new();
      hold_request      = 1'b0;
      no_idle           = 1'b0;
      reset             = 1'b1;
      req_push          = 1'b0;
      req_in_byte       = 8'd0;
      req_end_of_string = 1'b0;
      csr_we            = 1'b0;
      csr_wdata         = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Component mode: a reserved escape decodes to its character, and the
      // extreme plain bytes pass straight through.
      write_mode(1'b0);
      add_text("%3b", 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b1);
      send_all();
      wait_drained();

      // Full-URI mode: a kept escape, NUL which is never kept, a four-byte
      // sequence, a bad lead byte, a string cut inside an escape, and a bad
      // hex digit followed by a byte that is swallowed at the string end.
      write_mode(1'b1);
      add_text("%2F%00%F0%9F%98%80", 1'b1);
      add_text("%80", 1'b1);
      add_text("%4", 1'b1);
      add_text("%Gz", 1'b1);
      send_all();
      wait_drained();

      // Random phases alternate the mode. The second one forces the long
      // output stall, the third runs both sides without any idling.
      for (int p = 0; p < 4; p++) begin
         write_mode(p[0]);
         gen_random(PHASE_ITEMS);
         hold_request = (p == 1);
         no_idle      = (p == 2);
         send_all();
         wait_drained();
      end
      no_idle = 1'b0;

      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/upd_pkg.sv
rtl/upd_queue.sv
rtl/upd_front.sv
rtl/upd_back.sv
rtl/uri_percent_decoder.sv
tb/tb_top.sv
